// ===== design/fmacl_pkg.sv =====
// shared types, codes and helpers of the first-match acl classifier
package fmacl_pkg;

  localparam int ADDR_W   = 32;
  localparam int PLEN_W   = 6;
  localparam int PORT_W   = 17;
  localparam int PROTO_W  = 2;
  localparam int IDX_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [ADDR_W-1:0] ADDR_ALL  = 32'hFFFF_FFFF;
  localparam logic [PLEN_W-1:0] ADDR_BITS = 6'd32;

  localparam logic MODE_WRITE    = 1'b0;
  localparam logic MODE_CLASSIFY = 1'b1;

  localparam logic [PROTO_W-1:0] PROT_ANY = 2'd0;
  localparam logic [PROTO_W-1:0] PROT_TCP = 2'd1;

  localparam logic ACT_DENY = 1'b1;

  localparam int PORT_ANY_BIT = 16;

  // register index as carried by paddr bit 2
  localparam logic REG_RULE_COUNT = 1'b0;

  // an item travelling down the chain, with the match result gathered so far
  typedef struct packed {
    logic               mode;
    logic [IDX_W-1:0]   rule_index;
    logic               action;
    logic [PROTO_W-1:0] proto;
    logic [ADDR_W-1:0]  src_addr;
    logic [PLEN_W-1:0]  src_prefix;
    logic [ADDR_W-1:0]  dst_addr;
    logic [PLEN_W-1:0]  dst_prefix;
    logic [PORT_W-1:0]  sport;
    logic [PORT_W-1:0]  dport;
    logic               stateful;
    logic               hit;
    logic               verdict;
    logic               needs_state;
  } fmacl_tok_t;

  // one stored rule
  typedef struct packed {
    logic               action;
    logic [PROTO_W-1:0] proto;
    logic [ADDR_W-1:0]  src_addr;
    logic [PLEN_W-1:0]  src_prefix;
    logic [ADDR_W-1:0]  dst_addr;
    logic [PLEN_W-1:0]  dst_prefix;
    logic [PORT_W-1:0]  sport;
    logic [PORT_W-1:0]  dport;
    logic               stateful;
  } fmacl_rule_t;

  // prefix length above 32 acts as an exact match, zero as any address
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    if (plen >= ADDR_BITS) begin
      return ADDR_ALL;
    end
    return ~(ADDR_ALL >> plen);
  endfunction

  function automatic logic port_hit(input logic [PORT_W-1:0] rule_port,
                                    input logic [PORT_W-1:0] port);
    return rule_port[PORT_ANY_BIT] || (rule_port == port);
  endfunction

endpackage

// ===== design/fmacl_if.sv =====
// valid/ready channel interfaces for header items and verdict items
interface fmacl_in_if;
  import fmacl_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [IDX_W-1:0]   rule_index;
  logic               action;
  logic [PROTO_W-1:0] proto;
  logic [ADDR_W-1:0]  src_addr;
  logic [PLEN_W-1:0]  src_prefix;
  logic [ADDR_W-1:0]  dst_addr;
  logic [PLEN_W-1:0]  dst_prefix;
  logic [PORT_W-1:0]  sport;
  logic [PORT_W-1:0]  dport;
  logic               stateful;

  modport source (output valid, mode, rule_index, action, proto, src_addr, src_prefix,
                  dst_addr, dst_prefix, sport, dport, stateful, input ready);
  modport sink   (input valid, mode, rule_index, action, proto, src_addr, src_prefix,
                  dst_addr, dst_prefix, sport, dport, stateful, output ready);
endinterface

interface fmacl_out_if;
  logic valid;
  logic ready;
  logic verdict;
  logic needs_state;
  logic hit;

  modport source (output valid, verdict, needs_state, hit, input ready);
  modport sink   (input valid, verdict, needs_state, hit, output ready);
endinterface

// ===== design/fmacl_cell.sv =====
// one rule cell: holds a rule, captures writes aimed at it and matches passing headers
module fmacl_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  en,
  input  logic                  in_valid,
  input  fmacl_pkg::fmacl_tok_t in_tok,
  output logic                  out_valid,
  output fmacl_pkg::fmacl_tok_t out_tok
);
  import fmacl_pkg::*;

  logic        valid_r;
  fmacl_tok_t  tok_r;
  fmacl_tok_t  tok_nxt;
  fmacl_rule_t rule_r;
  logic        wr_hit;
  logic        match;

  assign wr_hit = in_valid && (in_tok.mode == MODE_WRITE)
                  && (32'(in_tok.rule_index) == CELL_IDX);

  always_comb begin
    match = en
      && ((rule_r.proto == PROT_ANY) || (rule_r.proto == in_tok.proto))
      && ((in_tok.src_addr & prefix_mask(rule_r.src_prefix))
          == (rule_r.src_addr & prefix_mask(rule_r.src_prefix)))
      && ((in_tok.dst_addr & prefix_mask(rule_r.dst_prefix))
          == (rule_r.dst_addr & prefix_mask(rule_r.dst_prefix)))
      && port_hit(rule_r.sport, in_tok.sport)
      && port_hit(rule_r.dport, in_tok.dport);
  end

  always_comb begin
    tok_nxt = in_tok;
    // first match wins, later cells leave the result alone
    if ((in_tok.mode == MODE_CLASSIFY) && !in_tok.hit && match) begin
      tok_nxt.hit         = 1'b1;
      tok_nxt.verdict     = rule_r.action;
      tok_nxt.needs_state = rule_r.stateful && (in_tok.proto == PROT_TCP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r <= tok_nxt;
      if (wr_hit) begin
        rule_r.action     <= in_tok.action;
        rule_r.proto      <= in_tok.proto;
        rule_r.src_addr   <= in_tok.src_addr;
        rule_r.src_prefix <= in_tok.src_prefix;
        rule_r.dst_addr   <= in_tok.dst_addr;
        rule_r.dst_prefix <= in_tok.dst_prefix;
        rule_r.sport      <= in_tok.sport;
        rule_r.dport      <= in_tok.dport;
        rule_r.stateful   <= in_tok.stateful;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_tok   = tok_r;

endmodule

// ===== design/first_match_acl_classifier.sv =====
// top level: rule cell chain, rule_count register and verdict output register
//
// channel  | direction | contents
// in_ch    | in        | rule write (mode 0) or packet header (mode 1)
// out_ch   | out       | verdict, needs_state, hit for each header item
// cfg_*    | in/out    | apb register port, rule_count at address 0
//
// one item enters per cycle while no verdict waits on out_ch; a header's verdict reaches out_ch
// through the registers of cell 0 up to cell RULE_DEPTH-1 in order, the output register last
// writes travel the same chain, so they take effect in order with headers
// the whole chain halts while a verdict waits on out_ch; in_ch.ready follows
// reset clears valid flags and rule_count only; rule entries are unset until written
module first_match_acl_classifier #(
  parameter int RULE_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  fmacl_in_if.sink                     in_ch,
  fmacl_out_if.source                  out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [fmacl_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [fmacl_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [fmacl_pkg::APB_DW-1:0] cfg_prdata,
  output logic                         cfg_pready
);
  import fmacl_pkg::*;

  logic [COUNT_W-1:0] rule_count_r;
  logic               out_valid_r;
  logic               verdict_r;
  logic               needs_state_r;
  logic               hit_r;
  logic               adv;
  fmacl_tok_t         head_tok;

  logic       valid_c [0:RULE_DEPTH];
  fmacl_tok_t tok_c   [0:RULE_DEPTH];

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_RULE_COUNT)
                      ? APB_DW'(rule_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_count_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == REG_RULE_COUNT)) begin
      rule_count_r <= cfg_pwdata[COUNT_W-1:0];
    end
  end

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    head_tok.mode          = in_ch.mode;
    head_tok.rule_index    = in_ch.rule_index;
    head_tok.action        = in_ch.action;
    head_tok.proto         = in_ch.proto;
    head_tok.src_addr      = in_ch.src_addr;
    head_tok.src_prefix    = in_ch.src_prefix;
    head_tok.dst_addr      = in_ch.dst_addr;
    head_tok.dst_prefix    = in_ch.dst_prefix;
    head_tok.sport         = in_ch.sport;
    head_tok.dport         = in_ch.dport;
    head_tok.stateful      = in_ch.stateful;
    head_tok.hit           = 1'b0;
    head_tok.verdict       = ACT_DENY;
    head_tok.needs_state   = 1'b0;
  end

  assign valid_c[0] = in_ch.valid;
  assign tok_c[0]   = head_tok;

  for (genvar g = 0; g < RULE_DEPTH; g++) begin : g_cell
    logic en;
    assign en = 32'(rule_count_r) > g;

    fmacl_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .en       (en),
      .in_valid (valid_c[g]),
      .in_tok   (tok_c[g]),
      .out_valid(valid_c[g+1]),
      .out_tok  (tok_c[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      // rule writes leave the chain without a result
      out_valid_r <= valid_c[RULE_DEPTH] && (tok_c[RULE_DEPTH].mode == MODE_CLASSIFY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      verdict_r     <= tok_c[RULE_DEPTH].verdict;
      needs_state_r <= tok_c[RULE_DEPTH].needs_state;
      hit_r         <= tok_c[RULE_DEPTH].hit;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.verdict     = verdict_r;
  assign out_ch.needs_state = needs_state_r;
  assign out_ch.hit         = hit_r;

endmodule

// ===== design/fmacl_checker.sv =====
// port-level checks on the classifier, bound to the top level
module fmacl_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic verdict,
  input logic needs_state,
  input logic hit
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(verdict) && $stable(needs_state) && $stable(hit))
    else $error("stalled result item changed");

  a_miss_deny: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !hit |-> verdict && !needs_state)
    else $error("miss without default deny");

  a_state_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && needs_state |-> hit)
    else $error("needs_state without a matched rule");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with no waiting result");

endmodule

bind first_match_acl_classifier fmacl_checker u_fmacl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .verdict    (out_ch.verdict),
  .needs_state(out_ch.needs_state),
  .hit        (out_ch.hit)
);
